>>> hw/rtl/plp_pkg.sv
// ----------------------------------------------------------------------------
// plp_pkg
// Widths and shared types of the point to line projection pipeline.
// ----------------------------------------------------------------------------
package plp_pkg;

    localparam int CW    = 32;           // coordinate width
    localparam int DW    = CW + 1;       // difference width
    localparam int PW    = 2 * DW;       // product of two differences
    localparam int SUMW  = PW + 1;       // sum of two products
    localparam int RW    = 2 * CW + 1;   // magnitude of dot, cross, squared length
    localparam int HW    = RW - CW;      // upper part of a split magnitude
    localparam int QD    = 2 * CW + 3;   // quotient bits, distance divide
    localparam int QO    = CW + 1;       // quotient bits, offset divide
    localparam int ND    = RW + QD;      // distance dividend
    localparam int NO    = RW + CW;      // offset dividend
    localparam int SW    = CW + 2;       // root width
    localparam int RMW   = SW + 2;       // root remainder width
    localparam int OFW   = SW + 1;       // signed offset width
    localparam int TW    = 16;           // threshold width
    localparam int IN_W  = 6 * CW;
    localparam int OUT_W = 3 * CW;

    typedef struct packed {
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic                 neg_x;
        logic                 neg_y;
        logic                 degen;
    } t_ctx;

    typedef struct packed {
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic signed [CW-1:0] fx;
        logic signed [CW-1:0] fy;
        logic                 fsat;
        logic                 degen;
    } t_tail;

endpackage

>>> hw/rtl/plp_prep.sv
// ----------------------------------------------------------------------------
// plp_prep
// Six stage front end: differences, products, dot/cross/length, magnitudes,
// split products and the dividends for the divide pipeline.
// ----------------------------------------------------------------------------
module plp_prep (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic signed [plp_pkg::CW-1:0]       i_px,
    input  logic signed [plp_pkg::CW-1:0]       i_py,
    input  logic signed [plp_pkg::CW-1:0]       i_sx,
    input  logic signed [plp_pkg::CW-1:0]       i_sy,
    input  logic signed [plp_pkg::CW-1:0]       i_ex,
    input  logic signed [plp_pkg::CW-1:0]       i_ey,
    output logic                                o_valid,
    output logic [plp_pkg::ND-1:0]              o_dist_num,
    output logic [plp_pkg::NO-1:0]              o_offx_num,
    output logic [plp_pkg::NO-1:0]              o_offy_num,
    output logic [plp_pkg::RW-1:0]              o_den,
    output plp_pkg::t_ctx                       o_ctx
);

    logic [5:0] r_v;

    // stage A
    logic signed [plp_pkg::DW-1:0] r_a_dx, r_a_dy, r_a_qx, r_a_qy;
    logic signed [plp_pkg::CW-1:0] r_a_px, r_a_py, r_a_sx, r_a_sy;
    // stage B
    logic signed [plp_pkg::PW-1:0] r_b_qxdx, r_b_qydy, r_b_qxdy, r_b_qydx;
    logic signed [plp_pkg::PW-1:0] r_b_dxdx, r_b_dydy, r_b_qxqx, r_b_qyqy;
    logic [plp_pkg::CW-1:0]        r_b_adx, r_b_ady;
    logic                          r_b_dxn, r_b_dyn;
    logic signed [plp_pkg::CW-1:0] r_b_px, r_b_py, r_b_sx, r_b_sy;
    // stage C
    logic signed [plp_pkg::SUMW-1:0] r_c_num, r_c_cross;
    logic [plp_pkg::RW-1:0]          r_c_den, r_c_qq;
    logic [plp_pkg::CW-1:0]          r_c_adx, r_c_ady;
    logic                            r_c_dxn, r_c_dyn;
    logic signed [plp_pkg::CW-1:0]   r_c_px, r_c_py, r_c_sx, r_c_sy;
    // stage D
    logic                   r_d_degen;
    logic [plp_pkg::RW-1:0] r_d_den, r_d_anum, r_d_acr, r_d_qq;
    logic [plp_pkg::CW-1:0] r_d_adx, r_d_ady;
    plp_pkg::t_ctx          r_d_ctx;
    // stage E
    logic [2*plp_pkg::HW-1:0]         r_e_chh;
    logic [plp_pkg::HW+plp_pkg::CW-1:0] r_e_chl, r_e_nhx, r_e_nhy;
    logic [2*plp_pkg::CW-1:0]         r_e_cll, r_e_nlx, r_e_nly;
    logic [plp_pkg::RW-1:0]           r_e_den, r_e_qq;
    plp_pkg::t_ctx                    r_e_ctx;
    // stage F
    logic [plp_pkg::ND-1:0] r_f_dist;
    logic [plp_pkg::NO-1:0] r_f_offx, r_f_offy;
    logic [plp_pkg::RW-1:0] r_f_den;
    plp_pkg::t_ctx          r_f_ctx;

    logic signed [plp_pkg::DW-1:0]   n_b_ndx, n_b_ndy;
    logic signed [plp_pkg::SUMW-1:0] n_d_nnum, n_d_ncr;
    logic                            n_d_degen;
    logic [2*plp_pkg::RW-1:0]        n_f_c2;

    always_comb begin
        n_b_ndx  = -r_a_dx;
        n_b_ndy  = -r_a_dy;
        n_d_nnum = -r_c_num;
        n_d_ncr  = -r_c_cross;
        n_d_degen = (r_c_den == '0);
        n_f_c2 = {r_e_chh, {(2*plp_pkg::CW){1'b0}}}
               + (2*plp_pkg::RW)'({r_e_chl, {plp_pkg::HW{1'b0}}})
               + (2*plp_pkg::RW)'(r_e_cll);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_dx <= plp_pkg::DW'(i_ex) - plp_pkg::DW'(i_sx);
            r_a_dy <= plp_pkg::DW'(i_ey) - plp_pkg::DW'(i_sy);
            r_a_qx <= plp_pkg::DW'(i_px) - plp_pkg::DW'(i_sx);
            r_a_qy <= plp_pkg::DW'(i_py) - plp_pkg::DW'(i_sy);
            r_a_px <= i_px;
            r_a_py <= i_py;
            r_a_sx <= i_sx;
            r_a_sy <= i_sy;

            r_b_qxdx <= r_a_qx * r_a_dx;
            r_b_qydy <= r_a_qy * r_a_dy;
            r_b_qxdy <= r_a_qx * r_a_dy;
            r_b_qydx <= r_a_qy * r_a_dx;
            r_b_dxdx <= r_a_dx * r_a_dx;
            r_b_dydy <= r_a_dy * r_a_dy;
            r_b_qxqx <= r_a_qx * r_a_qx;
            r_b_qyqy <= r_a_qy * r_a_qy;
            r_b_adx  <= r_a_dx[plp_pkg::DW-1] ? plp_pkg::CW'(n_b_ndx) : plp_pkg::CW'(r_a_dx);
            r_b_ady  <= r_a_dy[plp_pkg::DW-1] ? plp_pkg::CW'(n_b_ndy) : plp_pkg::CW'(r_a_dy);
            r_b_dxn  <= r_a_dx[plp_pkg::DW-1];
            r_b_dyn  <= r_a_dy[plp_pkg::DW-1];
            r_b_px   <= r_a_px;
            r_b_py   <= r_a_py;
            r_b_sx   <= r_a_sx;
            r_b_sy   <= r_a_sy;

            r_c_num   <= plp_pkg::SUMW'(r_b_qxdx) + plp_pkg::SUMW'(r_b_qydy);
            r_c_cross <= plp_pkg::SUMW'(r_b_qxdy) - plp_pkg::SUMW'(r_b_qydx);
            r_c_den   <= plp_pkg::RW'(r_b_dxdx[plp_pkg::PW-3:0])
                       + plp_pkg::RW'(r_b_dydy[plp_pkg::PW-3:0]);
            r_c_qq    <= plp_pkg::RW'(r_b_qxqx[plp_pkg::PW-3:0])
                       + plp_pkg::RW'(r_b_qyqy[plp_pkg::PW-3:0]);
            r_c_adx   <= r_b_adx;
            r_c_ady   <= r_b_ady;
            r_c_dxn   <= r_b_dxn;
            r_c_dyn   <= r_b_dyn;
            r_c_px    <= r_b_px;
            r_c_py    <= r_b_py;
            r_c_sx    <= r_b_sx;
            r_c_sy    <= r_b_sy;

            r_d_degen <= n_d_degen;
            r_d_den   <= n_d_degen ? plp_pkg::RW'(1) : r_c_den;
            r_d_anum  <= r_c_num[plp_pkg::SUMW-1] ? plp_pkg::RW'(n_d_nnum)
                                                  : plp_pkg::RW'(r_c_num);
            r_d_acr   <= r_c_cross[plp_pkg::SUMW-1] ? plp_pkg::RW'(n_d_ncr)
                                                    : plp_pkg::RW'(r_c_cross);
            r_d_qq    <= r_c_qq;
            r_d_adx   <= r_c_adx;
            r_d_ady   <= r_c_ady;
            r_d_ctx.px    <= r_c_px;
            r_d_ctx.py    <= r_c_py;
            r_d_ctx.sx    <= r_c_sx;
            r_d_ctx.sy    <= r_c_sy;
            r_d_ctx.neg_x <= r_c_num[plp_pkg::SUMW-1] ^ r_c_dxn;
            r_d_ctx.neg_y <= r_c_num[plp_pkg::SUMW-1] ^ r_c_dyn;
            r_d_ctx.degen <= n_d_degen;

            r_e_chh <= r_d_acr[plp_pkg::RW-1:plp_pkg::CW] * r_d_acr[plp_pkg::RW-1:plp_pkg::CW];
            r_e_chl <= r_d_acr[plp_pkg::RW-1:plp_pkg::CW] * r_d_acr[plp_pkg::CW-1:0];
            r_e_cll <= r_d_acr[plp_pkg::CW-1:0] * r_d_acr[plp_pkg::CW-1:0];
            r_e_nhx <= r_d_anum[plp_pkg::RW-1:plp_pkg::CW] * r_d_adx;
            r_e_nlx <= r_d_anum[plp_pkg::CW-1:0] * r_d_adx;
            r_e_nhy <= r_d_anum[plp_pkg::RW-1:plp_pkg::CW] * r_d_ady;
            r_e_nly <= r_d_anum[plp_pkg::CW-1:0] * r_d_ady;
            r_e_den <= r_d_den;
            r_e_qq  <= r_d_qq;
            r_e_ctx <= r_d_ctx;

            r_f_dist <= r_e_ctx.degen ? plp_pkg::ND'({r_e_qq, 2'b00}) : {n_f_c2, 2'b00};
            r_f_offx <= {r_e_nhx, {plp_pkg::CW{1'b0}}} + plp_pkg::NO'(r_e_nlx);
            r_f_offy <= {r_e_nhy, {plp_pkg::CW{1'b0}}} + plp_pkg::NO'(r_e_nly);
            r_f_den  <= r_e_den;
            r_f_ctx  <= r_e_ctx;
        end
    end

    assign o_valid    = r_v[5];
    assign o_dist_num = r_f_dist;
    assign o_offx_num = r_f_offx;
    assign o_offy_num = r_f_offy;
    assign o_den      = r_f_den;
    assign o_ctx      = r_f_ctx;

endmodule

>>> hw/rtl/plp_div.sv
// ----------------------------------------------------------------------------
// plp_div
// Pipelined restoring divider, one quotient bit per stage. The distance
// quotient runs through every stage; both offset quotients finish early and
// ride along with the divisor and context.
// ----------------------------------------------------------------------------
module plp_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [plp_pkg::ND-1:0]      i_dist_num,
    input  logic [plp_pkg::NO-1:0]      i_offx_num,
    input  logic [plp_pkg::NO-1:0]      i_offy_num,
    input  logic [plp_pkg::RW-1:0]      i_den,
    input  plp_pkg::t_ctx               i_ctx,
    output logic                        o_valid,
    output logic [plp_pkg::QD-1:0]      o_dist_q,
    output logic [plp_pkg::QO-1:0]      o_offx_q,
    output logic [plp_pkg::RW-1:0]      o_offx_rem,
    output logic [plp_pkg::QO-1:0]      o_offy_q,
    output logic [plp_pkg::RW-1:0]      o_offy_rem,
    output logic [plp_pkg::RW-1:0]      o_den,
    output plp_pkg::t_ctx               o_ctx
);

    localparam int OW = plp_pkg::RW + plp_pkg::QO;

    function automatic logic [plp_pkg::RW:0] div_step(input logic [plp_pkg::RW-1:0] rem,
                                                      input logic                   nb,
                                                      input logic [plp_pkg::RW-1:0] den);
        logic [plp_pkg::RW:0] t;
        logic [plp_pkg::RW:0] s;
        t = {rem, nb};
        s = t - {1'b0, den};
        if (t >= {1'b0, den}) begin
            div_step = {s[plp_pkg::RW-1:0], 1'b1};
        end else begin
            div_step = {t[plp_pkg::RW-1:0], 1'b0};
        end
    endfunction

    logic                   w_v   [0:plp_pkg::QD];
    logic [plp_pkg::ND-1:0] w_dw  [0:plp_pkg::QD];
    logic [OW-1:0]          w_xw  [0:plp_pkg::QD];
    logic [OW-1:0]          w_yw  [0:plp_pkg::QD];
    logic [plp_pkg::RW-1:0] w_den [0:plp_pkg::QD];
    plp_pkg::t_ctx          w_ctx [0:plp_pkg::QD];

    assign w_v[0]   = i_valid;
    assign w_dw[0]  = i_dist_num;
    assign w_xw[0]  = {1'b0, i_offx_num};
    assign w_yw[0]  = {1'b0, i_offy_num};
    assign w_den[0] = i_den;
    assign w_ctx[0] = i_ctx;

    for (genvar k = 0; k < plp_pkg::QD; k++) begin : g_stage
        logic                   r_v;
        logic [plp_pkg::ND-1:0] r_dw;
        logic [OW-1:0]          r_xw;
        logic [OW-1:0]          r_yw;
        logic [plp_pkg::RW-1:0] r_den;
        plp_pkg::t_ctx          r_ctx;
        logic [plp_pkg::RW:0]   n_d;
        logic [plp_pkg::RW:0]   n_x;
        logic [plp_pkg::RW:0]   n_y;

        always_comb begin
            n_d = div_step(w_dw[k][plp_pkg::ND-1:plp_pkg::QD], w_dw[k][plp_pkg::QD-1],
                           w_den[k]);
            n_x = div_step(w_xw[k][OW-1:plp_pkg::QO], w_xw[k][plp_pkg::QO-1], w_den[k]);
            n_y = div_step(w_yw[k][OW-1:plp_pkg::QO], w_yw[k][plp_pkg::QO-1], w_den[k]);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dw  <= {n_d[plp_pkg::RW:1], w_dw[k][plp_pkg::QD-2:0], n_d[0]};
                r_den <= w_den[k];
                r_ctx <= w_ctx[k];
                if (k < plp_pkg::QO) begin
                    r_xw <= {n_x[plp_pkg::RW:1], w_xw[k][plp_pkg::QO-2:0], n_x[0]};
                    r_yw <= {n_y[plp_pkg::RW:1], w_yw[k][plp_pkg::QO-2:0], n_y[0]};
                end else begin
                    r_xw <= w_xw[k];
                    r_yw <= w_yw[k];
                end
            end
        end

        assign w_v[k+1]   = r_v;
        assign w_dw[k+1]  = r_dw;
        assign w_xw[k+1]  = r_xw;
        assign w_yw[k+1]  = r_yw;
        assign w_den[k+1] = r_den;
        assign w_ctx[k+1] = r_ctx;
    end

    assign o_valid    = w_v[plp_pkg::QD];
    assign o_dist_q   = w_dw[plp_pkg::QD][plp_pkg::QD-1:0];
    assign o_offx_q   = w_xw[plp_pkg::QD][plp_pkg::QO-1:0];
    assign o_offx_rem = w_xw[plp_pkg::QD][OW-1:plp_pkg::QO];
    assign o_offy_q   = w_yw[plp_pkg::QD][plp_pkg::QO-1:0];
    assign o_offy_rem = w_yw[plp_pkg::QD][OW-1:plp_pkg::QO];
    assign o_den      = w_den[plp_pkg::QD];
    assign o_ctx      = w_ctx[plp_pkg::QD];

endmodule

>>> hw/rtl/plp_sqrt.sv
// ----------------------------------------------------------------------------
// plp_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module plp_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [plp_pkg::QD-1:0]      i_rad,
    input  plp_pkg::t_tail              i_tail,
    output logic                        o_valid,
    output logic [plp_pkg::SW-1:0]      o_root,
    output plp_pkg::t_tail              o_tail
);

    logic                      w_v    [0:plp_pkg::SW];
    logic [plp_pkg::RMW-1:0]   w_rem  [0:plp_pkg::SW];
    logic [plp_pkg::SW-1:0]    w_root [0:plp_pkg::SW];
    logic [2*plp_pkg::SW-1:0]  w_x    [0:plp_pkg::SW];
    plp_pkg::t_tail            w_tail [0:plp_pkg::SW];

    assign w_v[0]    = i_valid;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_x[0]    = (2*plp_pkg::SW)'(i_rad);
    assign w_tail[0] = i_tail;

    for (genvar k = 0; k < plp_pkg::SW; k++) begin : g_stage
        localparam int HI = 2 * (plp_pkg::SW - k) - 1;

        logic                      r_v;
        logic [plp_pkg::RMW-1:0]   r_rem;
        logic [plp_pkg::SW-1:0]    r_root;
        logic [2*plp_pkg::SW-1:0]  r_x;
        plp_pkg::t_tail            r_tail;
        logic [plp_pkg::RMW+1:0]   n_t;
        logic [plp_pkg::RMW+1:0]   n_trial;
        logic [plp_pkg::RMW+1:0]   n_diff;
        logic                      n_ge;

        always_comb begin
            n_t     = {w_rem[k], w_x[k][HI:HI-1]};
            n_trial = (plp_pkg::RMW+2)'({w_root[k], 2'b01});
            n_diff  = n_t - n_trial;
            n_ge    = (n_t >= n_trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= n_ge ? n_diff[plp_pkg::RMW-1:0] : n_t[plp_pkg::RMW-1:0];
                r_root <= {w_root[k][plp_pkg::SW-2:0], n_ge};
                r_x    <= w_x[k];
                r_tail <= w_tail[k];
            end
        end

        assign w_v[k+1]    = r_v;
        assign w_rem[k+1]  = r_rem;
        assign w_root[k+1] = r_root;
        assign w_x[k+1]    = r_x;
        assign w_tail[k+1] = r_tail;
    end

    assign o_valid = w_v[plp_pkg::SW];
    assign o_root  = w_root[plp_pkg::SW];
    assign o_tail  = w_tail[plp_pkg::SW];

endmodule

>>> hw/rtl/point_to_line_projection_unit.sv
// ----------------------------------------------------------------------------
// point_to_line_projection_unit
// Projects a query point onto the line through two points; returns the foot
// point, the distance to the line and degenerate/saturation flags.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis: one item = query point and two line points, all
//   signed 32-bit fixed point with 16 fraction bits.
//   Output stream m_axis: foot point, distance and two flags per item.
//   i_cfg_we/i_cfg_wdata write the 16-bit snap threshold (reset value 1);
//   write it only while no items are in flight.
//   The pipeline holds 6 front-end stages, 67 divide stages (one
//   quotient bit each), 2 foot stages, 34 square-root stages (one root bit
//   each) and the output register.
//   Throughput is one item per cycle while the output is not stalled. All
//   stages advance together; when the output register holds an item that is
//   not taken, the whole pipeline and o_s_axis_tready hold, and nothing is
//   lost or repeated. Empty stages move on while the output is empty.
//   Reset clears all valid bits and restores the threshold.
// ----------------------------------------------------------------------------
module point_to_line_projection_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [plp_pkg::TW-1:0]      i_cfg_wdata,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // point_x, point_y, line_start_x, line_start_y, line_end_x, line_end_y
    input  logic [plp_pkg::IN_W-1:0]    i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // foot_x, foot_y, distance
    output logic [plp_pkg::OUT_W-1:0]   o_m_axis_tdata,
    // degenerate_line, saturated
    output logic [1:0]                  o_m_axis_tuser
);

    localparam int CW = plp_pkg::CW;

    logic w_en;

    logic [plp_pkg::TW-1:0] r_thr;

    logic                   w_p_valid;
    logic [plp_pkg::ND-1:0] w_p_dist;
    logic [plp_pkg::NO-1:0] w_p_offx, w_p_offy;
    logic [plp_pkg::RW-1:0] w_p_den;
    plp_pkg::t_ctx          w_p_ctx;

    logic                   w_d_valid;
    logic [plp_pkg::QD-1:0] w_d_dist;
    logic [plp_pkg::QO-1:0] w_d_qx, w_d_qy;
    logic [plp_pkg::RW-1:0] w_d_rx, w_d_ry, w_d_den;
    plp_pkg::t_ctx          w_d_ctx;

    logic                           r_t1_v;
    logic signed [plp_pkg::OFW-1:0] r_t1_offx, r_t1_offy;
    logic [plp_pkg::QD-1:0]         r_t1_dist;
    plp_pkg::t_ctx                  r_t1_ctx;

    logic                   r_t2_v;
    logic [plp_pkg::QD-1:0] r_t2_dist;
    plp_pkg::t_tail         r_t2_tail;

    logic                   w_s_valid;
    logic [plp_pkg::SW-1:0] w_s_root;
    plp_pkg::t_tail         w_s_tail;

    logic              r_ov;
    logic [CW-1:0]     r_o_fx, r_o_fy, r_o_dist;
    logic              r_o_degen, r_o_sat;

    logic [plp_pkg::SW-1:0]         n_t1_magx, n_t1_magy;
    logic signed [plp_pkg::OFW:0]   n_t2_sumx, n_t2_sumy;
    logic                           n_t2_ovx, n_t2_ovy;
    logic [plp_pkg::SW:0]           n_o_inc;
    logic [plp_pkg::SW-1:0]         n_o_dist;
    logic                           n_o_dsat, n_o_snap;

    assign w_en            = !r_ov || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= plp_pkg::TW'(1);
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    plp_prep u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (i_s_axis_tvalid),
        .i_px       ($signed(i_s_axis_tdata[CW-1:0])),
        .i_py       ($signed(i_s_axis_tdata[2*CW-1:CW])),
        .i_sx       ($signed(i_s_axis_tdata[3*CW-1:2*CW])),
        .i_sy       ($signed(i_s_axis_tdata[4*CW-1:3*CW])),
        .i_ex       ($signed(i_s_axis_tdata[5*CW-1:4*CW])),
        .i_ey       ($signed(i_s_axis_tdata[6*CW-1:5*CW])),
        .o_valid    (w_p_valid),
        .o_dist_num (w_p_dist),
        .o_offx_num (w_p_offx),
        .o_offy_num (w_p_offy),
        .o_den      (w_p_den),
        .o_ctx      (w_p_ctx)
    );

    plp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (w_p_valid),
        .i_dist_num (w_p_dist),
        .i_offx_num (w_p_offx),
        .i_offy_num (w_p_offy),
        .i_den      (w_p_den),
        .i_ctx      (w_p_ctx),
        .o_valid    (w_d_valid),
        .o_dist_q   (w_d_dist),
        .o_offx_q   (w_d_qx),
        .o_offx_rem (w_d_rx),
        .o_offy_q   (w_d_qy),
        .o_offy_rem (w_d_ry),
        .o_den      (w_d_den),
        .o_ctx      (w_d_ctx)
    );

    // round half away from zero on magnitude, then apply sign
    always_comb begin
        n_t1_magx = plp_pkg::SW'(w_d_qx)
                  + plp_pkg::SW'({w_d_rx, 1'b0} >= {1'b0, w_d_den});
        n_t1_magy = plp_pkg::SW'(w_d_qy)
                  + plp_pkg::SW'({w_d_ry, 1'b0} >= {1'b0, w_d_den});
    end

    always_comb begin
        n_t2_sumx = (plp_pkg::OFW+1)'(r_t1_ctx.sx) + (plp_pkg::OFW+1)'(r_t1_offx);
        n_t2_sumy = (plp_pkg::OFW+1)'(r_t1_ctx.sy) + (plp_pkg::OFW+1)'(r_t1_offy);
        n_t2_ovx  = !((&n_t2_sumx[plp_pkg::OFW:CW-1]) || !(|n_t2_sumx[plp_pkg::OFW:CW-1]));
        n_t2_ovy  = !((&n_t2_sumy[plp_pkg::OFW:CW-1]) || !(|n_t2_sumy[plp_pkg::OFW:CW-1]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_v <= 1'b0;
            r_t2_v <= 1'b0;
        end else if (w_en) begin
            r_t1_v <= w_d_valid;
            r_t2_v <= r_t1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t1_offx <= w_d_ctx.neg_x ? -plp_pkg::OFW'(n_t1_magx) : plp_pkg::OFW'(n_t1_magx);
            r_t1_offy <= w_d_ctx.neg_y ? -plp_pkg::OFW'(n_t1_magy) : plp_pkg::OFW'(n_t1_magy);
            r_t1_dist <= w_d_dist;
            r_t1_ctx  <= w_d_ctx;

            r_t2_dist       <= r_t1_dist;
            r_t2_tail.px    <= r_t1_ctx.px;
            r_t2_tail.py    <= r_t1_ctx.py;
            r_t2_tail.fx    <= n_t2_ovx ? {n_t2_sumx[plp_pkg::OFW], {(CW-1){!n_t2_sumx[plp_pkg::OFW]}}}
                                        : n_t2_sumx[CW-1:0];
            r_t2_tail.fy    <= n_t2_ovy ? {n_t2_sumy[plp_pkg::OFW], {(CW-1){!n_t2_sumy[plp_pkg::OFW]}}}
                                        : n_t2_sumy[CW-1:0];
            r_t2_tail.fsat  <= n_t2_ovx || n_t2_ovy;
            r_t2_tail.degen <= r_t1_ctx.degen;
        end
    end

    plp_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_t2_v),
        .i_rad   (r_t2_dist),
        .i_tail  (r_t2_tail),
        .o_valid (w_s_valid),
        .o_root  (w_s_root),
        .o_tail  (w_s_tail)
    );

    // root is twice the distance; round half up
    always_comb begin
        n_o_inc  = {1'b0, w_s_root} + (plp_pkg::SW+1)'(1);
        n_o_dist = n_o_inc[plp_pkg::SW:1];
        n_o_dsat = |n_o_dist[plp_pkg::SW-1:CW];
        n_o_snap = !w_s_tail.degen && (n_o_dist < plp_pkg::SW'(r_thr));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= w_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_fx    <= n_o_snap ? w_s_tail.px : w_s_tail.fx;
            r_o_fy    <= n_o_snap ? w_s_tail.py : w_s_tail.fy;
            r_o_dist  <= n_o_dsat ? {CW{1'b1}} : n_o_dist[CW-1:0];
            r_o_degen <= w_s_tail.degen;
            r_o_sat   <= n_o_dsat || (w_s_tail.fsat && !n_o_snap && !w_s_tail.degen);
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {r_o_dist, r_o_fy, r_o_fx};
    assign o_m_axis_tuser  = {r_o_sat, r_o_degen};

endmodule

>>> hw/rtl/plp_chk.sv
// ----------------------------------------------------------------------------
// plp_chk
// Port-level checks of the point to line projection unit.
// ----------------------------------------------------------------------------
module plp_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_cfg_we,
    input logic [plp_pkg::TW-1:0]      i_cfg_wdata,
    input logic                        i_s_axis_tvalid,
    input logic                        o_s_axis_tready,
    input logic [plp_pkg::IN_W-1:0]    i_s_axis_tdata,
    input logic                        o_m_axis_tvalid,
    input logic                        i_m_axis_tready,
    input logic [plp_pkg::OUT_W-1:0]   o_m_axis_tdata,
    input logic [1:0]                  o_m_axis_tuser
);

    localparam int CW = plp_pkg::CW;

    logic [CW-1:0] w_fx, w_fy, w_dist;
    logic          w_unused;

    assign w_fx     = o_m_axis_tdata[CW-1:0];
    assign w_fy     = o_m_axis_tdata[2*CW-1:CW];
    assign w_dist   = o_m_axis_tdata[3*CW-1:2*CW];
    assign w_unused = i_cfg_we ^ (^i_cfg_wdata) ^ i_s_axis_tvalid ^ (^i_s_axis_tdata);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("output item changed while stalled");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready == (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("input ready does not follow output stall");

    a_degen_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] && o_m_axis_tuser[1] |->
            w_dist == {CW{1'b1}})
        else $error("degenerate item saturated without clipped distance");

    a_sat_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n || w_unused === 1'bx)
        o_m_axis_tvalid && o_m_axis_tuser[1] |->
            w_dist == {CW{1'b1}} ||
            w_fx == {1'b0, {(CW-1){1'b1}}} || w_fx == {1'b1, {(CW-1){1'b0}}} ||
            w_fy == {1'b0, {(CW-1){1'b1}}} || w_fy == {1'b1, {(CW-1){1'b0}}})
        else $error("saturated flag without a clipped result");

endmodule

bind point_to_line_projection_unit plp_chk u_plp_chk (.*);

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stream test of the point to line projection unit. A driver offers items from
// a queue, a monitor checks each result against an exact wide-integer
// prediction of foot point, distance and flags, with random idling on both
// sides, a long output hold-off and several snap-threshold settings.
// ----------------------------------------------------------------------------
module tb_top;
    import plp_pkg::*;

    typedef bit [263:0] wide_t;

    typedef struct packed {
        logic signed [CW-1:0] ey;
        logic signed [CW-1:0] ex;
        logic signed [CW-1:0] sy;
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] py;
        logic signed [CW-1:0] px;
    } seg_item_t;

    typedef struct packed {
        logic [CW-1:0]        span;
        logic signed [CW-1:0] fy;
        logic signed [CW-1:0] fx;
        logic                 sat;
        logic                 degen;
    } foot_t;

    localparam int HOLD_CYCLES = 400;
    localparam int WDOG_LIMIT  = 5000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [TW-1:0]     i_cfg_wdata = '0;
    logic              i_s_axis_tvalid = 1'b0;
    logic              o_s_axis_tready;
    logic [IN_W-1:0]   i_s_axis_tdata = '0;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  o_m_axis_tdata;
    logic [1:0]        o_m_axis_tuser;

    point_to_line_projection_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    seg_item_t pending_q[$];
    foot_t     foot_q[$];
    bit [15:0] snap_thr = 16'd1;
    int        snd_idle = 0;
    int        rcv_stall = 0;
    bit        hold_go = 1'b0;
    bit        hold_done = 1'b0;
    int        hold_left = 0;
    int        n_err = 0;
    int        n_in = 0;
    int        n_out = 0;
    int        n_snap = 0;
    int        n_degen = 0;
    int        n_sat = 0;
    int        idle_cnt = 0;

    function automatic void queue_item(input seg_item_t it);
        pending_q.insert(pending_q.size(), it);
    endfunction

    function automatic wide_t mag_of(input logic signed [127:0] v);
        return (v < 0) ? wide_t'(-v) : wide_t'(v);
    endfunction

    function automatic bit [63:0] isqrt64(input wide_t a);
        bit [63:0] res;
        bit [63:0] cand;
        res = '0;
        for (int k = 63; k >= 0; k--) begin
            cand = res | (64'd1 << k);
            if (wide_t'(cand) * wide_t'(cand) <= a) res = cand;
        end
        return res;
    endfunction

    // round(sqrt(a/den)), ties upward
    function automatic bit [63:0] round_root(input wide_t a, input wide_t den);
        bit [63:0] r1;
        r1 = isqrt64((a << 2) / den) + 64'd1;
        return r1 >> 1;
    endfunction

    // round(num*d/den), ties away from zero
    function automatic longint proj_offset(input logic signed [127:0] num,
                                           input longint d, input wide_t den);
        wide_t     p;
        wide_t     q;
        wide_t     rem;
        bit [63:0] mag;
        p = mag_of(num) * mag_of(d);
        q = p / den;
        rem = p % den;
        mag = (q >> 64) != 0 ? {64{1'b1}} : q[63:0];
        if ((rem << 1) >= den) mag = mag + 64'd1;
        if (mag > (64'd1 << 62)) mag = 64'd1 << 62;
        return ((num < 0) != (d < 0)) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic logic signed [CW-1:0] clip_coord(input longint v, inout bit flag);
        if (v > 64'sd2147483647) begin
            flag = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            flag = 1'b1;
            return 32'sh80000000;
        end
        return v[CW-1:0];
    endfunction

    function automatic foot_t project(input seg_item_t it, input bit [15:0] thr);
        foot_t               r;
        longint              dx;
        longint              dy;
        longint              qx;
        longint              qy;
        logic signed [127:0] num;
        logic signed [127:0] crs;
        wide_t               den;
        wide_t               cm;
        bit [63:0]           span;
        bit                  fsat;
        dx = longint'(it.ex) - longint'(it.sx);
        dy = longint'(it.ey) - longint'(it.sy);
        qx = longint'(it.px) - longint'(it.sx);
        qy = longint'(it.py) - longint'(it.sy);
        den = mag_of(dx) * mag_of(dx) + mag_of(dy) * mag_of(dy);
        r = '0;
        fsat = 1'b0;
        if (den == 0) begin
            r.degen = 1'b1;
            span = round_root(mag_of(qx) * mag_of(qx) + mag_of(qy) * mag_of(qy), wide_t'(1));
            r.fx = it.sx;
            r.fy = it.sy;
        end else begin
            num = 128'(qx) * 128'(dx) + 128'(qy) * 128'(dy);
            crs = 128'(qx) * 128'(dy) - 128'(qy) * 128'(dx);
            cm = mag_of(crs);
            span = round_root(cm * cm, den);
            r.fx = clip_coord(longint'(it.sx) + proj_offset(num, dx, den), fsat);
            r.fy = clip_coord(longint'(it.sy) + proj_offset(num, dy, den), fsat);
            if (span < 64'(thr)) begin
                r.fx = it.px;
                r.fy = it.py;
            end else if (fsat) begin
                r.sat = 1'b1;
            end
        end
        if (span > 64'hffff_ffff) begin
            span = 64'hffff_ffff;
            r.sat = 1'b1;
        end
        r.span = span[CW-1:0];
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        foot_t f;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                f = project(pending_q[0], snap_thr);
                foot_q.insert(foot_q.size(), f);
                n_in++;
                if (!f.degen && f.fx == pending_q[0].px && f.fy == pending_q[0].py
                    && f.span < snap_thr) n_snap++;
                n_degen += f.degen;
                n_sat += f.sat;
                void'(pending_q.pop_front());
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (pending_q.size() != 0 && $urandom_range(99) >= snd_idle) begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata <= pending_q[0];
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // output hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_go && !hold_done && hold_left == 0) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        foot_t got;
        foot_t want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= rcv_stall);
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = {o_m_axis_tdata, o_m_axis_tuser[1], o_m_axis_tuser[0]};
                n_out++;
                if (foot_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10) $display("unexpected result %h", got);
                end else begin
                    want = foot_q.pop_front();
                    if (got !== want) begin
                        n_err++;
                        if (n_err <= 10)
                            $display({"mismatch item %0d: fx %h/%h fy %h/%h dist %h/%h",
                                      " degen %b/%b sat %b/%b (exp/act)"},
                                     n_out, want.fx, got.fx, want.fy, got.fy,
                                     want.span, got.span,
                                     want.degen, got.degen, want.sat, got.sat);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
            || (pending_q.size() == 0 && foot_q.size() == 0)) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= WDOG_LIMIT) begin
            $display("timeout: %0d items pending, %0d results due", pending_q.size(),
                     foot_q.size());
            $display("tb: failure");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    function automatic logic signed [CW-1:0] rnd32();
        return $urandom();
    endfunction

    function automatic seg_item_t gen_item();
        seg_item_t it;
        int        kind;
        int        k;
        kind = $urandom_range(99);
        it = {rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), rnd32()};
        if (kind < 20) begin
            // noise: full-range coordinates
        end else if (kind < 30) begin
            it.ex = it.sx;
            it.ey = it.sy;
            if (kind < 25) begin
                it.px = it.sx + $signed($urandom_range(2000)) - 1000;
                it.py = it.sy + $signed($urandom_range(2000)) - 1000;
            end
        end else begin
            // point near a short line, so that snapping is reached
            it.ex = it.sx + $signed($urandom_range(1 << 18)) - (1 << 17);
            it.ey = it.sy + $signed($urandom_range(1 << 18)) - (1 << 17);
            k = $signed($urandom_range(16)) - 8;
            it.px = it.sx + (k * (it.ex - it.sx)) / 4;
            it.py = it.sy + (k * (it.ey - it.sy)) / 4;
            if (kind < 70) begin
                it.px = it.px + $signed($urandom_range(1 << 12)) - (1 << 11);
                it.py = it.py + $signed($urandom_range(1 << 12)) - (1 << 11);
            end else if (kind < 85) begin
                it.px = it.px + $signed($urandom_range(1 << 20)) - (1 << 19);
                it.py = it.py + $signed($urandom_range(1 << 20)) - (1 << 19);
            end
        end
        return it;
    endfunction

    task automatic wait_drained();
        while (pending_q.size() != 0 || foot_q.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_thr(input bit [15:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        snap_thr = v;
    endtask

    task automatic run_phase(input bit [15:0] thr, input int idle, input int stall,
                             input int n, input bit press);
        write_thr(thr);
        snd_idle = idle;
        rcv_stall = stall;
        for (int i = 0; i < n; i++) queue_item(gen_item());
        if (press) hold_go <= 1'b1;
        wait_drained();
    endtask

    localparam logic signed [CW-1:0] MX = 32'sh7fffffff;
    localparam logic signed [CW-1:0] MN = 32'sh80000000;

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset threshold, directed extremes
        queue_item({MX, MX, MN, MN, 32'sd0, 32'sd0});
        queue_item({MN, MN, MX, MX, MX, MN});
        queue_item({MX, MN, MX, MN, MN, MX});
        queue_item({MN, MN, MN, MN, MX, MX});
        queue_item({MX, MX, MX, MX, MN, MN});
        queue_item({32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0});
        queue_item({32'sd5, 32'sd5, 32'sd0, 32'sd0, 32'sd3, 32'sd3});
        queue_item({32'sd5, 32'sd5, 32'sd0, 32'sd0, 32'sd3, 32'sd4});
        queue_item({MX, MN + 1, MN, MN, MN, MX});
        queue_item({32'sd1, MX, 32'sd0, MN, 32'sd0, MX});
        queue_item({32'sd65536, 32'sd0, 32'sd0, 32'sd0, 32'sd32768, 32'sd1});
        queue_item({32'sd1, 32'sd1, 32'sd0, 32'sd0, MN, MX});
        queue_item({-32'sd1, -32'sd1, 32'sd0, 32'sd0, MX, MN});
        queue_item({32'sd2, 32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd0});
        queue_item({32'sd3, 32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd0});
        queue_item({32'sd0, 32'sd1, 32'sd0, 32'sd0, 32'sd1, 32'sd1});
        wait_drained();

        run_phase(16'd0,     0,  0,  300, 1'b0);
        run_phase(16'd65535, 77, 0,  300, 1'b0);
        run_phase(16'd1000,  0,  77, 300, 1'b0);
        run_phase(16'd1,     6,  6,  300, 1'b1);
        run_phase(16'($urandom()), 0, 0, 300, 1'b0);
        run_phase(16'd30000, 6,  6,  330, 1'b0);

        $display("summary: %0d items in, %0d results out, %0d snapped, %0d degenerate,",
                 n_in, n_out, n_snap, n_degen);
        $display("         %0d saturated, thresholds 0..65535, idle and hold-off phases",
                 n_sat);
        if (n_err == 0 && foot_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d errors", n_err);
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/plp_pkg.sv
hw/rtl/plp_prep.sv
hw/rtl/plp_div.sv
hw/rtl/plp_sqrt.sv
hw/rtl/point_to_line_projection_unit.sv
hw/rtl/plp_chk.sv
dv/tb_top.sv
